### hw/rtl/assert_macros.svh
// Assertion macros shared by the kd-tree search RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define KDK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define KDK_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

### hw/rtl/kdk_pkg.sv
// Package for the kd-tree k-nearest search: sizes, payload types,
// controller states and the command/status structs. No dependencies.
package kdk_pkg;

  localparam int NODES       = 4096;
  localparam int NODE_W      = $clog2(NODES);
  localparam int K_MAX       = 64;
  localparam int CNT_W       = $clog2(K_MAX + 1);
  localparam int COORD_W     = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int DIST_W      = 2 * COORD_W + 1;
  localparam int ACC_W       = DIST_W + 1;
  localparam int AXIS_W      = 2;
  localparam int RAD_W       = 24;
  localparam int STACK_DEPTH = NODE_W;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int CAND_DEPTH  = K_MAX + 2;
  localparam int CAND_AW     = $clog2(CAND_DEPTH);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [AXIS_W-1:0] AX_X = 2'd0;
  localparam logic [AXIS_W-1:0] AX_Y = 2'd1;

  typedef enum logic [1:0] {PH_DOWN, PH_FAR, PH_DONE} ph_t;

  typedef enum logic [2:0] {SQ_RAD, SQ_AXIS, SQ_X, SQ_Y, SQ_Z} sq_sel_t;

  typedef enum logic [1:0] {A_S, A_2P, A_I} a_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RAD, ST_INIT, ST_READ, ST_EVAL, ST_PLANE,
    ST_DY, ST_DZ, ST_DSUM, ST_CMP,
    ST_B_RD, ST_B_LD, ST_S_RD, ST_S_CMP, ST_S_END,
    ST_EMIT, ST_E_RD, ST_E_OUT, ST_EMPTY
  } state_t;

  typedef struct packed {
    logic                      cmd;
    logic [NODE_W-1:0]         node_addr;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [AXIS_W-1:0]         split_axis;
    logic [RAD_W-1:0]          max_radius;
    logic [CNT_W-1:0]          k_wanted;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [DIST_W-1:0] dist_sq;
    logic [CNT_W-1:0]  found_count;
    logic [DIST_W-1:0] bound_sq;
    logic              is_empty;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [AXIS_W-1:0]  axis;
  } tree_ent_t;

  typedef struct packed {
    logic [DIST_W-1:0] dsq;
    logic [NODE_W-1:0] node;
  } cand_t;

  typedef struct packed {
    logic [NODE_W-1:0] idx;
    ph_t               ph;
  } stack_ent_t;

  typedef struct packed {
    logic    accept;
    sq_sel_t sq_sel;
    a_sel_t  a_sel;
    logic    q_init;
    logic    push_near;
    logic    plane;
    logic    pop;
    logic    acc_load;
    logic    acc_add;
    logic    append;
    logic    build_start;
    logic    bld_load;
    logic    replace_start;
    logic    sift_fin;
    logic    sift_step;
    logic    s_dec;
    logic    set_built;
    logic    emit_first;
    logic    emit_next;
    logic    out_empty;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic internal;
    ph_t  ph;
    logic k_zero;
    logic nc_zero;
    logic dist_lt;
    logic found_lt_k;
    logic built;
    logic half_zero;
    logic s_one;
    logic p_leaf;
    logic sift_stop;
    logic sp_one;
    logic found_zero;
    logic last_out;
  } ctl_sts_t;

endpackage

### hw/rtl/kdk_if.sv
// Valid/ready channel interfaces for the kd-tree search block.
// Depends on kdk_pkg for field widths.
interface kdk_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [kdk_pkg::NODE_W-1:0]         node_addr;
  logic signed [kdk_pkg::COORD_W-1:0] pos_x;
  logic signed [kdk_pkg::COORD_W-1:0] pos_y;
  logic signed [kdk_pkg::COORD_W-1:0] pos_z;
  logic [kdk_pkg::AXIS_W-1:0]         split_axis;
  logic [kdk_pkg::RAD_W-1:0]          max_radius;
  logic [kdk_pkg::CNT_W-1:0]          k_wanted;
  modport source (output valid, cmd, node_addr, pos_x, pos_y, pos_z, split_axis,
                  max_radius, k_wanted, input ready);
  modport sink (input valid, cmd, node_addr, pos_x, pos_y, pos_z, split_axis,
                max_radius, k_wanted, output ready);
endinterface

interface kdk_out_if;
  logic                       valid;
  logic                       ready;
  logic [kdk_pkg::NODE_W-1:0] node_index;
  logic [kdk_pkg::DIST_W-1:0] dist_sq;
  logic [kdk_pkg::CNT_W-1:0]  found_count;
  logic [kdk_pkg::DIST_W-1:0] bound_sq;
  logic                       is_empty;
  logic                       last;
  modport source (output valid, node_index, dist_sq, found_count, bound_sq, is_empty,
                  last, input ready);
  modport sink (input valid, node_index, dist_sq, found_count, bound_sq, is_empty,
                last, output ready);
endinterface

interface kdk_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kdk_pkg::NODE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/kdk_ctrl.sv
// Controller state machine of the kd-tree search: sequences walk, heap
// and emission. Depends on kdk_pkg; drives kdk_datapath by ctl_cmd_t.
module kdk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kdk_pkg::ctl_sts_t sts,
  output kdk_pkg::ctl_cmd_t cmd
);

  kdk_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kdk_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sq_sel = kdk_pkg::SQ_RAD;
    cmd.a_sel  = kdk_pkg::A_I;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      kdk_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.is_query) state_nxt = kdk_pkg::ST_RAD;
        end
      end
      kdk_pkg::ST_RAD: begin
        cmd.sq_sel = kdk_pkg::SQ_RAD;
        state_nxt  = kdk_pkg::ST_INIT;
      end
      kdk_pkg::ST_INIT: begin
        cmd.q_init = 1'b1;
        state_nxt  = (sts.k_zero || sts.nc_zero) ? kdk_pkg::ST_EMIT : kdk_pkg::ST_READ;
      end
      kdk_pkg::ST_READ: state_nxt = kdk_pkg::ST_EVAL;
      kdk_pkg::ST_EVAL: begin
        priority if (sts.ph == kdk_pkg::PH_DOWN && sts.internal) begin
          cmd.push_near = 1'b1;
          state_nxt     = kdk_pkg::ST_READ;
        end else if (sts.ph == kdk_pkg::PH_FAR) begin
          cmd.sq_sel = kdk_pkg::SQ_AXIS;
          state_nxt  = kdk_pkg::ST_PLANE;
        end else begin
          cmd.sq_sel = kdk_pkg::SQ_X;
          state_nxt  = kdk_pkg::ST_DY;
        end
      end
      kdk_pkg::ST_PLANE: begin
        cmd.plane = 1'b1;
        state_nxt = kdk_pkg::ST_READ;
      end
      kdk_pkg::ST_DY: begin
        cmd.acc_load = 1'b1;
        cmd.sq_sel   = kdk_pkg::SQ_Y;
        state_nxt    = kdk_pkg::ST_DZ;
      end
      kdk_pkg::ST_DZ: begin
        cmd.acc_add = 1'b1;
        cmd.sq_sel  = kdk_pkg::SQ_Z;
        state_nxt   = kdk_pkg::ST_DSUM;
      end
      kdk_pkg::ST_DSUM: begin
        cmd.acc_add = 1'b1;
        state_nxt   = kdk_pkg::ST_CMP;
      end
      kdk_pkg::ST_CMP: begin
        priority if (!sts.dist_lt || sts.found_lt_k) begin
          cmd.append = sts.dist_lt;
          cmd.pop    = 1'b1;
          state_nxt  = sts.sp_one ? kdk_pkg::ST_EMIT : kdk_pkg::ST_READ;
        end else if (!sts.built && !sts.half_zero) begin
          cmd.build_start = 1'b1;
          state_nxt       = kdk_pkg::ST_B_RD;
        end else begin
          cmd.set_built     = 1'b1;
          cmd.replace_start = 1'b1;
          state_nxt         = kdk_pkg::ST_S_RD;
        end
      end
      kdk_pkg::ST_B_RD: begin
        cmd.a_sel = kdk_pkg::A_S;
        state_nxt = kdk_pkg::ST_B_LD;
      end
      kdk_pkg::ST_B_LD: begin
        cmd.bld_load = 1'b1;
        state_nxt    = kdk_pkg::ST_S_RD;
      end
      kdk_pkg::ST_S_RD: begin
        cmd.a_sel = kdk_pkg::A_2P;
        if (sts.p_leaf) begin
          cmd.sift_fin = 1'b1;
          state_nxt    = kdk_pkg::ST_S_END;
        end else begin
          state_nxt = kdk_pkg::ST_S_CMP;
        end
      end
      kdk_pkg::ST_S_CMP: begin
        cmd.a_sel = kdk_pkg::A_2P;
        if (sts.sift_stop) begin
          cmd.sift_fin = 1'b1;
          state_nxt    = kdk_pkg::ST_S_END;
        end else begin
          cmd.sift_step = 1'b1;
          state_nxt     = kdk_pkg::ST_S_RD;
        end
      end
      kdk_pkg::ST_S_END: begin
        priority if (sts.built) begin
          cmd.pop   = 1'b1;
          state_nxt = sts.sp_one ? kdk_pkg::ST_EMIT : kdk_pkg::ST_READ;
        end else if (sts.s_one) begin
          cmd.set_built     = 1'b1;
          cmd.replace_start = 1'b1;
          state_nxt         = kdk_pkg::ST_S_RD;
        end else begin
          cmd.s_dec = 1'b1;
          state_nxt = kdk_pkg::ST_B_RD;
        end
      end
      kdk_pkg::ST_EMIT: begin
        if (sts.found_zero) begin
          state_nxt = kdk_pkg::ST_EMPTY;
        end else begin
          cmd.emit_first = 1'b1;
          state_nxt      = kdk_pkg::ST_E_RD;
        end
      end
      kdk_pkg::ST_E_RD: begin
        cmd.a_sel = kdk_pkg::A_I;
        state_nxt = kdk_pkg::ST_E_OUT;
      end
      kdk_pkg::ST_E_OUT: begin
        cmd.a_sel = kdk_pkg::A_I;
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last_out) begin
            state_nxt = kdk_pkg::ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = kdk_pkg::ST_E_RD;
          end
        end
      end
      kdk_pkg::ST_EMPTY: begin
        cmd.out_empty = 1'b1;
        out_valid     = 1'b1;
        if (out_ready) state_nxt = kdk_pkg::ST_IDLE;
      end
      default: state_nxt = kdk_pkg::ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/kdk_datapath.sv
// Datapath of the kd-tree search: tree memory, walk stack, squarer,
// candidate heap memory and result payload. Depends on kdk_pkg, assert_macros.svh.
`include "assert_macros.svh"

module kdk_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [kdk_pkg::NODE_W-1:0] cfg_data,
  input  kdk_pkg::in_item_t  in_item,
  input  kdk_pkg::ctl_cmd_t  cmd,
  output kdk_pkg::ctl_sts_t  sts,
  output kdk_pkg::out_item_t out_item
);

  localparam int CW = kdk_pkg::COORD_W;

  // query and configuration
  logic [kdk_pkg::NODE_W-1:0]  node_count_r;
  logic [CW-1:0]               q_x_r, q_y_r, q_z_r;
  logic [kdk_pkg::RAD_W-1:0]   rad_r;
  logic [kdk_pkg::CNT_W-1:0]   k_r;
  logic [kdk_pkg::DIST_W-1:0]  bound_r;
  logic [kdk_pkg::CNT_W-1:0]   found_r;
  logic                        built_r;

  // walk
  kdk_pkg::tree_ent_t  tree_mem [kdk_pkg::NODES];
  kdk_pkg::tree_ent_t  tree_rd_r;
  kdk_pkg::stack_ent_t stack_r [kdk_pkg::STACK_DEPTH];
  logic [kdk_pkg::SP_W-1:0] sp_r;
  logic [kdk_pkg::SP_W-1:0] top_ptr;
  kdk_pkg::stack_ent_t top;

  // squarer and distance accumulator
  logic signed [kdk_pkg::DIFF_W-1:0]   dx, dy, dz, d_ax, sq_in;
  logic signed [2*kdk_pkg::DIFF_W-1:0] sq_prod;
  logic [kdk_pkg::DIST_W-1:0]          sq_r;
  logic [kdk_pkg::ACC_W-1:0]           acc_r;
  logic                                d_pos;
  logic [kdk_pkg::NODE_W-1:0]          near_c, far_c;

  // candidate heap
  kdk_pkg::cand_t cand_mem [kdk_pkg::CAND_DEPTH];
  kdk_pkg::cand_t rd_a_r, rd_b_r, hv_r, cj, cand_wdata;
  logic [kdk_pkg::CAND_AW-1:0] p_r, s_r, i_r, addr_a, addr_b, cand_waddr, j_idx;
  logic [kdk_pkg::CAND_AW:0]   p2;
  logic                        strict_r, j_right, cand_we;

  assign top_ptr = sp_r - kdk_pkg::SP_W'(1);
  assign top     = stack_r[top_ptr];

  assign dx = $signed({q_x_r[CW-1], q_x_r}) - $signed({tree_rd_r.x[CW-1], tree_rd_r.x});
  assign dy = $signed({q_y_r[CW-1], q_y_r}) - $signed({tree_rd_r.y[CW-1], tree_rd_r.y});
  assign dz = $signed({q_z_r[CW-1], q_z_r}) - $signed({tree_rd_r.z[CW-1], tree_rd_r.z});

  // axis codes two and three split on z
  always_comb begin
    priority case (tree_rd_r.axis)
      kdk_pkg::AX_X: d_ax = dx;
      kdk_pkg::AX_Y: d_ax = dy;
      default:       d_ax = dz;
    endcase
  end

  assign d_pos  = !d_ax[kdk_pkg::DIFF_W-1] && (d_ax != '0);
  assign near_c = {top.idx[kdk_pkg::NODE_W-2:0], d_pos};
  assign far_c  = {top.idx[kdk_pkg::NODE_W-2:0], !d_pos};

  always_comb begin
    unique case (cmd.sq_sel)
      kdk_pkg::SQ_RAD:  sq_in = $signed({1'b0, rad_r});
      kdk_pkg::SQ_AXIS: sq_in = d_ax;
      kdk_pkg::SQ_X:    sq_in = dx;
      kdk_pkg::SQ_Y:    sq_in = dy;
      kdk_pkg::SQ_Z:    sq_in = dz;
      default:          sq_in = dz;
    endcase
  end

  assign sq_prod = sq_in * sq_in;

  always_ff @(posedge clk) begin
    sq_r <= sq_prod[kdk_pkg::DIST_W-1:0];
    if (cmd.acc_load) acc_r <= {1'b0, sq_r};
    else if (cmd.acc_add) acc_r <= acc_r + {1'b0, sq_r};
  end

  // tree memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.cmd == kdk_pkg::CMD_LOAD) begin
      tree_mem[in_item.node_addr] <= {in_item.pos_x, in_item.pos_y, in_item.pos_z,
                                      in_item.split_axis};
    end
    tree_rd_r <= tree_mem[top.idx];
  end

  // query capture, bound, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      k_r          <= '0;
      found_r      <= '0;
      built_r      <= 1'b0;
      sp_r         <= '0;
    end else begin
      if (cfg_we) node_count_r <= cfg_data;
      if (cmd.accept && in_item.cmd == kdk_pkg::CMD_QUERY) begin
        k_r     <= (in_item.k_wanted > kdk_pkg::CNT_W'(kdk_pkg::K_MAX)) ?
                   kdk_pkg::CNT_W'(kdk_pkg::K_MAX) : in_item.k_wanted;
        found_r <= '0;
        built_r <= 1'b0;
      end
      if (cmd.append) found_r <= found_r + kdk_pkg::CNT_W'(1);
      if (cmd.set_built) built_r <= 1'b1;
      priority if (cmd.q_init) begin
        sp_r <= kdk_pkg::SP_W'(1);
      end else if (cmd.push_near || (cmd.plane && sq_r < bound_r)) begin
        sp_r <= sp_r + kdk_pkg::SP_W'(1);
      end else if (cmd.pop) begin
        sp_r <= top_ptr;
      end else begin
        sp_r <= sp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_x_r <= in_item.pos_x;
      q_y_r <= in_item.pos_y;
      q_z_r <= in_item.pos_z;
      rad_r <= in_item.max_radius;
    end
    if (cmd.q_init) begin
      bound_r <= sq_r;
    end else if (built_r && cand_we && !cmd.append &&
                 cand_waddr == kdk_pkg::CAND_AW'(1)) begin
      bound_r <= cand_wdata.dsq;  // new heap top during a replacement
    end
  end

  // walk stack
  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      stack_r[0] <= {kdk_pkg::NODE_W'(1), kdk_pkg::PH_DOWN};
    end
    if (cmd.push_near) begin
      stack_r[top_ptr].ph <= kdk_pkg::PH_FAR;
      stack_r[sp_r]       <= {near_c, kdk_pkg::PH_DOWN};
    end
    if (cmd.plane) begin
      stack_r[top_ptr].ph <= kdk_pkg::PH_DONE;
      if (sq_r < bound_r) stack_r[sp_r] <= {far_c, kdk_pkg::PH_DOWN};
    end
  end

  // heap sift
  assign p2      = {p_r, 1'b0};
  assign j_right = (p2 < {1'b0, found_r}) && (rd_a_r.dsq < rd_b_r.dsq);
  assign cj      = j_right ? rd_b_r : rd_a_r;
  assign j_idx   = j_right ? kdk_pkg::CAND_AW'(p2 + 1'b1) : kdk_pkg::CAND_AW'(p2);

  always_comb begin
    unique case (cmd.a_sel)
      kdk_pkg::A_S:  addr_a = s_r;
      kdk_pkg::A_2P: addr_a = p2[kdk_pkg::CAND_AW-1:0];
      kdk_pkg::A_I:  addr_a = i_r;
      default:       addr_a = i_r;
    endcase
  end
  assign addr_b = kdk_pkg::CAND_AW'(p2 + 1'b1);

  always_comb begin
    cand_we    = cmd.append || cmd.sift_fin || cmd.sift_step;
    cand_waddr = p_r;
    cand_wdata = hv_r;
    priority if (cmd.append) begin
      cand_waddr = kdk_pkg::CAND_AW'(found_r + 1'b1);
      cand_wdata = {acc_r[kdk_pkg::DIST_W-1:0], top.idx};
    end else if (cmd.sift_step) begin
      cand_wdata = cj;
    end else begin
      cand_wdata = hv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_we) cand_mem[cand_waddr] <= cand_wdata;
    rd_a_r <= cand_mem[addr_a];
    rd_b_r <= cand_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.build_start) s_r <= kdk_pkg::CAND_AW'(found_r >> 1);
    else if (cmd.s_dec) s_r <= s_r - kdk_pkg::CAND_AW'(1);
    priority if (cmd.replace_start) begin
      hv_r     <= {acc_r[kdk_pkg::DIST_W-1:0], top.idx};
      p_r      <= kdk_pkg::CAND_AW'(1);
      strict_r <= 1'b1;
    end else if (cmd.bld_load) begin
      hv_r     <= rd_a_r;
      p_r      <= s_r;
      strict_r <= 1'b0;
    end else if (cmd.sift_step) begin
      p_r <= j_idx;
    end else begin
      p_r <= p_r;
    end
    if (cmd.emit_first) i_r <= kdk_pkg::CAND_AW'(1);
    else if (cmd.emit_next) i_r <= i_r + kdk_pkg::CAND_AW'(1);
  end

  // status
  always_comb begin
    sts.is_query   = (in_item.cmd == kdk_pkg::CMD_QUERY);
    sts.internal   = ({1'b0, top.idx} + 1'b1) < {2'b00, node_count_r[kdk_pkg::NODE_W-1:1]};
    sts.ph         = top.ph;
    sts.k_zero     = (k_r == '0);
    sts.nc_zero    = (node_count_r == '0);
    sts.dist_lt    = acc_r < {1'b0, bound_r};
    sts.found_lt_k = found_r < k_r;
    sts.built      = built_r;
    sts.half_zero  = (found_r >> 1) == '0;
    sts.s_one      = (s_r == kdk_pkg::CAND_AW'(1));
    sts.p_leaf     = p2 > {1'b0, found_r};
    sts.sift_stop  = strict_r ? (hv_r.dsq > cj.dsq) : (hv_r.dsq >= cj.dsq);
    sts.sp_one     = (sp_r == kdk_pkg::SP_W'(1));
    sts.found_zero = (found_r == '0);
    sts.last_out   = (kdk_pkg::CNT_W'(i_r) == found_r);
  end

  always_comb begin
    out_item.node_index  = cmd.out_empty ? '0 : rd_a_r.node;
    out_item.dist_sq     = cmd.out_empty ? '0 : rd_a_r.dsq;
    out_item.found_count = found_r;
    out_item.bound_sq    = bound_r;
    out_item.is_empty    = cmd.out_empty;
    out_item.last        = cmd.out_empty || sts.last_out;
  end

  `KDK_ASSERT(a_sp_range, sp_r <= kdk_pkg::SP_W'(kdk_pkg::STACK_DEPTH), "walk stack overflow")
  `KDK_ASSERT(a_found_le_k, found_r <= k_r, "more candidates than wanted")
  `KDK_ASSERT_IMPLY(a_cand_addr, cand_we, (cand_waddr != '0) && (kdk_pkg::CNT_W'(cand_waddr) <= k_r), "candidate write outside heap")

endmodule

### hw/rtl/kd_tree_k_nearest_search.sv
// Top level of the kd-tree k-nearest search block.
// Depends on kdk_pkg, kdk_if, kdk_ctrl and kdk_datapath.
//
// Usage:
//   cfg_ch  : write node_count (always ready), only while the block is idle.
//   in_ch   : requests. cmd load writes one tree node (slot, position, axis)
//             and gives no result; cmd query runs a k-nearest search.
//   out_ch  : one result per found node in candidate slot order, last set on
//             the final one, or a single empty marker when nothing was found.
// Sequence:
//   A load is accepted in idle; a query runs the RAD and INIT states, then
//   per stack step READ and EVAL for a descent, plus PLANE for a far-side
//   plane test, or plus DY, DZ, DSUM and CMP for a node distance test; a
//   full heap adds sift steps (one-time build over k/2 slots, then at most
//   log2(k)+1 levels per replacement). Emission reads each result (E_RD),
//   then holds it on out_ch (E_OUT) until taken. The shared 25x25 squarer
//   and one tree read port set the walk rate. in_ch is ready only when idle.
// Reset: synchronous, active low; clears node_count, the controller and the
//   walk stack pointer. Tree contents stay undefined until loaded.
// Stall: while out_ch is not ready the current result holds steady.
module kd_tree_k_nearest_search (
  input logic       clk,
  input logic       rst_n,
  kdk_cfg_if.sink   cfg_ch,
  kdk_in_if.sink    in_ch,
  kdk_out_if.source out_ch
);

  kdk_pkg::ctl_cmd_t  cmd;
  kdk_pkg::ctl_sts_t  sts;
  kdk_pkg::in_item_t  in_item;
  kdk_pkg::out_item_t out_item;

  // configuration register never stalls
  assign cfg_ch.ready = 1'b1;

  assign in_item = {in_ch.cmd, in_ch.node_addr, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                    in_ch.split_axis, in_ch.max_radius, in_ch.k_wanted};

  kdk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kdk_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.data),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  assign out_ch.node_index  = out_item.node_index;
  assign out_ch.dist_sq     = out_item.dist_sq;
  assign out_ch.found_count = out_item.found_count;
  assign out_ch.bound_sq    = out_item.bound_sq;
  assign out_ch.is_empty    = out_item.is_empty;
  assign out_ch.last        = out_item.last;

endmodule
